[sv/tfmc_pkg.sv]
// Shared types and constants for the tiered fare least-cost path block.
package tfmc_pkg;

	// Station store geometry
	localparam int STATION_DEPTH = 16384;
	localparam int IDX_W = $clog2(STATION_DEPTH);
	localparam int CNT_W = IDX_W + 1;

	// Field widths
	localparam int POS_W = 31;
	localparam int COST_W = 32;
	localparam int CFG_W = 31;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIER1_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIER2_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIER3_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIER1_COST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIER2_COST = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIER3_COST = 3'd5;

	// Input item
	typedef struct packed {
		logic [POS_W-1:0] position;
		logic first_station;
		logic last_station;
	} station_t;

	// Result item
	typedef struct packed {
		logic [COST_W-1:0] least_cost;
		logic reachable;
		logic is_last;
	} fare_t;

	// One station store entry
	typedef struct packed {
		logic reach;
		logic [COST_W-1:0] cost;
		logic [POS_W-1:0] pos;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

[sv/tfmc_ram.sv]
// Generic simple dual-port RAM with registered read.
module tfmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/tiered_fare_min_cost_path.sv]
// Tiered fare least-cost path: top level with walk-back sequencer and station store.
//
// Stations stream in travel order; a station with first_station set opens a journey at
// cost zero. Every station is kept, while there is room, in a 16384-entry RAM (position,
// cost, reachable), and each new station walks back over stored stations, newest first,
// until a hop exceeds tier3_limit or the oldest is priced, pricing each hop by the first
// tier whose limit covers it and keeping the least saturated total. One result transfer
// follows every station transfer. A first station or an empty journey goes straight to
// the result step; otherwise each stored station passes through the hop distance, tier
// select and sum steps in turn, and a hop that is too long ends the walk after the tier
// select. A finished result waits in the output register, so the next station is taken
// meanwhile; that next item holds in its final step while the earlier result is still
// stalled at the output. The RAM needs no clearing after reset, so stations are taken
// from the first cycle. Configuration is always ready and must only be written while
// the block is idle.
module tiered_fare_min_cost_path (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            station_valid,
	output logic                            station_stall,
	input  tfmc_pkg::station_t              station,
	output logic                            fare_valid,
	input  logic                            fare_stall,
	output tfmc_pkg::fare_t                 fare,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tfmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tfmc_pkg::CFG_W-1:0]      cfg_data
);

	import tfmc_pkg::*;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIFF = 3'd1;
	localparam logic [2:0] S_TIER = 3'd2;
	localparam logic [2:0] S_ACC  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;

	// Configuration registers
	logic [CFG_W-1:0] tier1_limit_q, tier2_limit_q, tier3_limit_q;
	logic [CFG_W-1:0] tier1_cost_q, tier2_cost_q, tier3_cost_q;

	// Journey and walk state
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  j_q;
	logic [POS_W-1:0]  pos_q;
	logic              last_q;
	logic              reach_q;
	logic [COST_W-1:0] best_q;
	logic signed [POS_W:0] diff_q;
	logic [CFG_W-1:0]  hop_fare_q;
	logic              fare_valid_q;
	fare_t             fare_q;

	// RAM port signals
	logic              ram_we, ram_re;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	entry_t            ram_wdata, ram_rdata;

	logic accept, done_go, store_full;
	logic signed [POS_W:0] diff_now;
	logic [COST_W:0]   sum_wide;
	logic [COST_W-1:0] sum_sat;
	logic [COST_W-1:0] best_out;

	assign cfg_ready = 1'b1;
	assign station_stall = (state_q != S_IDLE);
	assign accept = station_valid && !station_stall;
	assign fare_valid = fare_valid_q;
	assign fare = fare_q;

	assign done_go = (state_q == S_DONE) && (!fare_valid_q || !fare_stall);
	assign store_full = (cnt_q == CNT_W'(STATION_DEPTH));
	assign best_out = reach_q ? best_q : '0;

	// Shared arithmetic: signed hop distance, then saturating fare sum
	assign diff_now = $signed({1'b0, pos_q}) - $signed({1'b0, ram_rdata.pos});
	assign sum_wide = {1'b0, ram_rdata.cost} + {{(COST_W + 1 - CFG_W){1'b0}}, hop_fare_q};
	assign sum_sat = sum_wide[COST_W] ? '1 : sum_wide[COST_W-1:0];

	// RAM read on accept (newest station) and after each priced station
	always_comb begin
		ram_re = 1'b0;
		ram_raddr = j_q - IDX_W'(1);
		if (state_q == S_IDLE) begin
			ram_re = accept && !station.first_station && (cnt_q != '0);
			ram_raddr = cnt_q[IDX_W-1:0] - IDX_W'(1);
		end else if (state_q == S_ACC) begin
			ram_re = (j_q != '0);
		end
	end

	// RAM write of the finished station, unless the store is full
	assign ram_we = done_go && !store_full;
	assign ram_waddr = cnt_q[IDX_W-1:0];
	always_comb begin
		ram_wdata.reach = reach_q;
		ram_wdata.cost = best_out;
		ram_wdata.pos = pos_q;
	end

	tfmc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STATION_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tier1_limit_q <= CFG_W'(1);
			tier2_limit_q <= CFG_W'(2);
			tier3_limit_q <= CFG_W'(3);
			tier1_cost_q <= CFG_W'(1);
			tier2_cost_q <= CFG_W'(2);
			tier3_cost_q <= CFG_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TIER1_LIMIT: tier1_limit_q <= cfg_data;
				REG_TIER2_LIMIT: tier2_limit_q <= cfg_data;
				REG_TIER3_LIMIT: tier3_limit_q <= cfg_data;
				REG_TIER1_COST: tier1_cost_q <= cfg_data;
				REG_TIER2_COST: tier2_cost_q <= cfg_data;
				REG_TIER3_COST: tier3_cost_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= station.position;
			last_q <= station.first_station ? station.last_station : station.last_station;
		end
		if (state_q == S_DIFF) begin
			diff_q <= diff_now;
		end
		// tier select on the registered distance
		if (state_q == S_TIER) begin
			if (diff_q <= $signed({1'b0, tier1_limit_q})) begin
				hop_fare_q <= tier1_cost_q;
			end else if (diff_q <= $signed({1'b0, tier2_limit_q})) begin
				hop_fare_q <= tier2_cost_q;
			end else begin
				hop_fare_q <= tier3_cost_q;
			end
		end
		if (done_go) begin
			fare_q.least_cost <= best_out;
			fare_q.reachable <= reach_q;
			fare_q.is_last <= last_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			j_q <= '0;
			reach_q <= 1'b0;
			best_q <= '1;
			fare_valid_q <= 1'b0;
		end else begin
			if (fare_valid_q && !fare_stall) begin
				fare_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (station.first_station) begin
							cnt_q <= '0;
							reach_q <= 1'b1;
							best_q <= '0;
							state_q <= S_DONE;
						end else begin
							reach_q <= 1'b0;
							best_q <= '1;
							j_q <= cnt_q[IDX_W-1:0] - IDX_W'(1);
							state_q <= (cnt_q == '0) ? S_DONE : S_DIFF;
						end
					end
				end
				S_DIFF: begin
					state_q <= S_TIER;
				end
				S_TIER: begin
					// a hop beyond the third tier ends the walk
					if (diff_q > $signed({1'b0, tier3_limit_q})) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (ram_rdata.reach) begin
						if (!reach_q || sum_sat < best_q) begin
							best_q <= sum_sat;
						end
						reach_q <= 1'b1;
					end
					if (j_q == '0) begin
						state_q <= S_DONE;
					end else begin
						j_q <= j_q - IDX_W'(1);
						state_q <= S_DIFF;
					end
				end
				S_DONE: begin
					if (done_go) begin
						fare_valid_q <= 1'b1;
						if (!store_full) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The stored station count never passes the store depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(STATION_DEPTH))
		else $error("station count beyond store depth");

	// Every walked entry lies below the stored count
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIFF || state_q == S_TIER || state_q == S_ACC)
		|-> ({1'b0, j_q} < cnt_q))
		else $error("walk index outside stored stations");

	// A first station goes straight to the result at cost zero
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && station.first_station
		|=> (state_q == S_DONE) && reach_q && (best_q == '0) && (cnt_q == '0))
		else $error("first station not set up at cost zero");

	// Once reachable, a station stays reachable for the rest of its walk
	a_reach_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) && ($past(state_q) != S_IDLE) && $past(reach_q)
		|-> reach_q)
		else $error("reachable flag dropped during walk");

	// An unreachable result carries zero cost
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fare_valid && !fare.reachable |-> (fare.least_cost == '0))
		else $error("unreachable result with nonzero cost");
`endif

endmodule

[verif/tb.sv]
// Self-checking testbench for the tiered fare least-cost path block.
`timescale 1ns / 100ps

module tb;
	import tfmc_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ROUND_ITEMS = 125;

	logic clk = 1'b0;
	logic arst_n;
	logic station_valid;
	logic station_stall;
	station_t station;
	logic fare_valid;
	logic fare_stall = 1'b0;
	fare_t fare;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// Tier settings as the block should hold them
	logic [CFG_W-1:0] lim1, lim2, lim3, cost1, cost2, cost3;

	// Journey kept by the predictor
	logic [POS_W-1:0] stop_pos [STATION_DEPTH];
	logic [COST_W-1:0] stop_cost [STATION_DEPTH];
	logic stop_reach [STATION_DEPTH];
	int stop_count;

	fare_t expected_fares [$];
	int fare_errors = 0;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left = 0;

	tiered_fare_min_cost_path u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.station_valid (station_valid),
		.station_stall (station_stall),
		.station       (station),
		.fare_valid    (fare_valid),
		.fare_stall    (fare_stall),
		.fare          (fare),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("tiered_fare_min_cost_path test failed");
		$finish;
	end

	// Least fare for one station; updates the stored journey
	function automatic fare_t compute_fare(input station_t s);
		fare_t f;
		longint d;
		logic [COST_W-1:0] hop;
		logic [COST_W:0] sum;
		logic [COST_W-1:0] cand;
		logic [COST_W-1:0] best;
		logic reach;
		int j;
		reach = 1'b0;
		best = '1;
		if (s.first_station) begin
			stop_count = 0;
			reach = 1'b1;
			best = '0;
		end else begin
			// newest first, stop at the first hop beyond the third tier
			for (j = stop_count; j > 0; j--) begin
				d = longint'(s.position) - longint'(stop_pos[j-1]);
				if (d > longint'(lim3))
					break;
				if (d <= longint'(lim1))
					hop = {1'b0, cost1};
				else if (d <= longint'(lim2))
					hop = {1'b0, cost2};
				else
					hop = {1'b0, cost3};
				if (stop_reach[j-1]) begin
					sum = {1'b0, stop_cost[j-1]} + {1'b0, hop};
					cand = sum[COST_W] ? '1 : sum[COST_W-1:0];
					if (!reach || cand < best)
						best = cand;
					reach = 1'b1;
				end
			end
			if (!reach)
				best = '0;
		end
		// a full store keeps its contents
		if (stop_count < STATION_DEPTH) begin
			stop_pos[stop_count] = s.position;
			stop_cost[stop_count] = best;
			stop_reach[stop_count] = reach;
			stop_count++;
		end
		f.least_cost = best;
		f.reachable = reach;
		f.is_last = s.last_station;
		return f;
	endfunction

	// Result side: random or long stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			fare_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			fare_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Compare every result transfer with the oldest prediction
	always @(posedge clk) begin : check_fares
		fare_t want;
		if (arst_n && fare_valid && !fare_stall) begin
			if (expected_fares.size() == 0) begin
				fare_errors++;
				if (fare_errors <= 10)
					$display("%0t: fare transfer with nothing expected: cost %h reach %b last %b",
						$time, fare.least_cost, fare.reachable, fare.is_last);
			end else begin
				want = expected_fares.pop_front();
				if (fare.least_cost !== want.least_cost) begin
					fare_errors++;
					if (fare_errors <= 10)
						$display("%0t: least_cost exp %h got %h", $time,
							want.least_cost, fare.least_cost);
				end
				if (fare.reachable !== want.reachable) begin
					fare_errors++;
					if (fare_errors <= 10)
						$display("%0t: reachable exp %b got %b", $time,
							want.reachable, fare.reachable);
				end
				if (fare.is_last !== want.is_last) begin
					fare_errors++;
					if (fare_errors <= 10)
						$display("%0t: is_last exp %b got %b", $time,
							want.is_last, fare.is_last);
				end
			end
		end
	end

	// One station transfer, then a random gap
	task automatic send_station(input logic [POS_W-1:0] pos, input logic start_flag,
			input logic dest_flag);
		station_t s;
		s.position = pos;
		s.first_station = start_flag;
		s.last_station = dest_flag;
		station <= s;
		station_valid <= 1'b1;
		@(posedge clk);
		while (station_stall) @(posedge clk);
		expected_fares.push_back(compute_fare(s));
		if ($urandom_range(0, 99) < send_idle_pct) begin
			station_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
	endtask

	task automatic wait_for_fares;
		station_valid <= 1'b0;
		while (expected_fares.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TIER1_LIMIT: lim1 = val;
			REG_TIER2_LIMIT: lim2 = val;
			REG_TIER3_LIMIT: lim3 = val;
			REG_TIER1_COST: cost1 = val;
			REG_TIER2_COST: cost2 = val;
			REG_TIER3_COST: cost3 = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Reprogram all tiers once the block has gone quiet
	task automatic set_tiers(input logic [CFG_W-1:0] l1, input logic [CFG_W-1:0] l2,
			input logic [CFG_W-1:0] l3, input logic [CFG_W-1:0] c1,
			input logic [CFG_W-1:0] c2, input logic [CFG_W-1:0] c3);
		wait_for_fares();
		repeat (4) @(posedge clk);
		write_reg(REG_TIER1_LIMIT, l1);
		write_reg(REG_TIER2_LIMIT, l2);
		write_reg(REG_TIER3_LIMIT, l3);
		write_reg(REG_TIER1_COST, c1);
		write_reg(REG_TIER2_COST, c2);
		write_reg(REG_TIER3_COST, c3);
	endtask

	// Next position: near a tier boundary, beyond reach, repeated or backwards
	function automatic logic [POS_W-1:0] next_position(input logic [POS_W-1:0] prev);
		longint bound;
		longint step;
		bound = 0;
		case ($urandom_range(0, 9))
			0: step = 0;
			1: step = -longint'($urandom_range(1, 64));
			2, 3: bound = longint'(lim1);
			4, 5: bound = longint'(lim2);
			6, 7: bound = longint'(lim3);
			default: step = longint'(lim3) + 1 + $urandom_range(0, 64);
		endcase
		if (bound != 0 || step == 0) begin
			step = bound;
			case ($urandom_range(0, 3))
				0: step = bound - 1;
				1: step = bound + 1;
				2: step = longint'($urandom_range(0, 32'(bound)));
				default: ;
			endcase
		end
		return prev + 31'(step);
	endfunction

	// Well-formed journeys with random content, plus stray stations
	task automatic run_journeys(input int n_items);
		int sent;
		int len;
		int k;
		logic [POS_W-1:0] pos;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_station(31'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				sent++;
			end else begin
				pos = $urandom_range(0, 1) ? 31'($urandom) : 31'($urandom_range(0, 1000));
				send_station(pos, 1'b1, $urandom_range(0, 19) == 0);
				len = $urandom_range(1, 20);
				for (k = 0; k < len; k++) begin
					pos = next_position(pos);
					send_station(pos, 1'b0, k == len - 1 || $urandom_range(0, 19) == 0);
				end
				sent += len + 1;
			end
		end
	endtask

	task automatic apply_style(input int style);
		logic [CFG_W-1:0] l1;
		l1 = 31'($urandom_range(0, 4));
		case (style)
			0: set_tiers(l1, l1 + 31'($urandom_range(0, 4)), l1 + 31'($urandom_range(0, 8)),
				31'($urandom_range(0, 20)), 31'($urandom_range(0, 20)),
				31'($urandom_range(0, 20)));
			1: set_tiers(31'($urandom), 31'($urandom), 31'($urandom),
				31'($urandom), 31'($urandom), 31'($urandom));
			2: set_tiers('0, '0, '0, '1, '1, '1);
			3: set_tiers('1, '1, '1, '1, '1, '1);
			4: set_tiers(31'($urandom_range(5, 12)), 31'($urandom_range(0, 4)),
				31'($urandom_range(2, 9)), 31'($urandom_range(0, 50)),
				31'($urandom_range(0, 50)), 31'($urandom_range(0, 50)));
			default: set_tiers(31'd1, 31'd2, 31'd3, 31'd1, 31'd2, 31'd3);
		endcase
	endtask

	// Stations before any journey start are unreachable
	task automatic test_no_journey;
		send_station(31'd5, 1'b0, 1'b0);
		send_station('1, 1'b0, 1'b1);
	endtask

	// Reset tiers: every tier, a hop too long, a backwards position
	task automatic test_default_tiers;
		send_station(31'd0, 1'b1, 1'b1);
		send_station(31'd100, 1'b1, 1'b0);
		send_station(31'd101, 1'b0, 1'b0);
		send_station(31'd103, 1'b0, 1'b0);
		send_station(31'd106, 1'b0, 1'b0);
		send_station(31'd110, 1'b0, 1'b0);
		send_station(31'd109, 1'b0, 1'b1);
	endtask

	task automatic test_zero_tiers;
		set_tiers('0, '0, '0, '0, '0, '0);
		send_station(31'd0, 1'b1, 1'b0);
		send_station(31'd0, 1'b0, 1'b0);
		send_station(31'd1, 1'b0, 1'b0);
		send_station(31'd0, 1'b0, 1'b1);
	endtask

	// Chained maximum fares run into the cost ceiling
	task automatic test_saturation;
		set_tiers('1, '1, 31'd1, '1, '0, '0);
		send_station(31'd0, 1'b1, 1'b0);
		send_station(31'd1, 1'b0, 1'b0);
		send_station(31'd2, 1'b0, 1'b0);
		send_station(31'd3, 1'b0, 1'b0);
		send_station(31'd4, 1'b0, 1'b1);
	endtask

	// Tier limits not ascending
	task automatic test_out_of_order;
		set_tiers(31'd2, 31'd1, 31'd5, 31'd10, 31'd20, 31'd30);
		send_station(31'd0, 1'b1, 1'b0);
		send_station(31'd1, 1'b0, 1'b0);
		send_station(31'd3, 1'b0, 1'b0);
		send_station(31'd5, 1'b0, 1'b1);
	endtask

	// Stations after the destination keep extending the journey
	task automatic test_after_destination;
		set_tiers(31'd1, 31'd2, 31'd3, 31'd1, 31'd2, 31'd3);
		send_station(31'd10, 1'b1, 1'b0);
		send_station(31'd11, 1'b0, 1'b1);
		send_station(31'd12, 1'b0, 1'b0);
		send_station(31'd13, 1'b0, 1'b1);
	endtask

	// Long receiver hold-off with the sender pushing, then a sender pause
	task automatic test_backpressure;
		int k;
		int saved_pct;
		logic [POS_W-1:0] pos;
		set_tiers(31'd2, 31'd4, 31'd6, 31'd1, 31'd3, 31'd5);
		saved_pct = send_idle_pct;
		send_idle_pct = 0;
		hold_left <= HOLD_CYCLES;
		pos = 31'($urandom_range(0, 1000));
		send_station(pos, 1'b1, 1'b0);
		for (k = 0; k < 30; k++) begin
			pos = next_position(pos);
			send_station(pos, 1'b0, k == 29);
		end
		send_idle_pct = saved_pct;
		wait_for_fares();
		for (k = 0; k < 5; k++) begin
			pos = next_position(pos);
			send_station(pos, 1'b0, k == 4);
		end
	endtask

	task automatic test_random;
		int mode;
		int round;
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 63;
				end
				1: begin
					send_idle_pct = 63;
					recv_idle_pct = 27;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (round = 0; round < 4; round++) begin
				apply_style((mode * 4 + round) % 6);
				run_journeys(RANDOM_ROUND_ITEMS);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		station_valid = 1'b0;
		station = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		lim1 = 31'd1;
		lim2 = 31'd2;
		lim3 = 31'd3;
		cost1 = 31'd1;
		cost2 = 31'd2;
		cost3 = 31'd3;
		stop_count = 0;
		send_idle_pct = 27;
		recv_idle_pct = 63;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_journey();
		test_default_tiers();
		test_zero_tiers();
		test_saturation();
		test_out_of_order();
		test_after_destination();
		test_backpressure();
		test_random();

		wait_for_fares();
		repeat (20) @(posedge clk);
		if (fare_errors == 0 && expected_fares.size() == 0) begin
			$display("tiered_fare_min_cost_path test passed");
		end else begin
			$display("tiered_fare_min_cost_path test failed");
		end
		$finish;
	end

endmodule

[filelist.f]
sv/tfmc_pkg.sv
sv/tfmc_ram.sv
sv/tiered_fare_min_cost_path.sv
verif/tb.sv
